// File: sv/serial_acia_register_block_top_defines.svh
// Assertion macros shared by the serial register block.
// Define ASSERT_OFF to compile all assertions out.
`ifndef SERIAL_ACIA_REGISTER_BLOCK_TOP_DEFINES_SVH
`define SERIAL_ACIA_REGISTER_BLOCK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define SABR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define SABR_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SABR_ASSERT(lbl, clk, rst, prop, msg)
`define SABR_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: sv/sabr_pkg.sv
package sabr_pkg;

   // Item kinds on the request channel.
   typedef enum logic [2:0] {
      KIND_READ      = 3'd0,
      KIND_WRITE     = 3'd1,
      KIND_CLEAR_IRQ = 3'd2,
      KIND_LINE_BYTE = 3'd3,
      KIND_TICK      = 3'd4,
      KIND_MRESET    = 3'd5
   } kind_type;

   // CPU register select.
   typedef enum logic [1:0] {
      SEL_DATA    = 2'd0,
      SEL_STATUS  = 2'd1,
      SEL_COMMAND = 2'd2,
      SEL_CONTROL = 2'd3
   } reg_sel_type;

   // Mode bit positions decoded from the command register.
   localparam int MB_DTR = 0;
   localparam int MB_RTS = 1;
   localparam int MB_RXI = 2;
   localparam int MB_TXI = 3;
   localparam int MB_ECH = 4;

   // Stop bit codes.
   localparam logic [1:0] STOP_ONE      = 2'd0;
   localparam logic [1:0] STOP_ONE_HALF = 2'd1;
   localparam logic [1:0] STOP_TWO      = 2'd2;

   // Parity code for no parity.
   localparam logic [2:0] PARITY_NONE = 3'd0;

   // Reset and load values.
   localparam logic [7:0] CMD_RESET_VALUE = 8'h02;
   localparam logic [4:0] CMD_SOFT_LOW    = 5'b00010;
   localparam logic [7:0] RETRIGGER_LOAD  = 8'hFF;

   typedef struct packed {
      kind_type    kind;
      reg_sel_type reg_select;
      logic [7:0]  byte_value;
      logic        link_present;
      logic        tx_accept;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [7:0]  status_byte;
      logic        irq_pulse;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_refused;
      logic [16:0] baud_rate;
      logic [3:0]  word_bits;
      logic [1:0]  stop_code;
      logic [2:0]  parity_code;
      logic        dtr_out;
      logic        rts_out;
   } rsp_type;

   // Requests from the register logic to the receive FIFO.
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctl_type;

   // FIFO state seen by the register logic.
   typedef struct packed {
      logic has_data;
      logic full;
   } fifo_sts_type;

   // Line rate from the low nibble of the control register.
   function automatic logic [16:0] baud_lookup(input logic [3:0] code);
      logic [16:0] rate;
      case (code)
         4'd0:    rate = 17'd115200;
         4'd1:    rate = 17'd50;
         4'd2:    rate = 17'd75;
         4'd3:    rate = 17'd110;
         4'd4:    rate = 17'd135;
         4'd5:    rate = 17'd150;
         4'd6:    rate = 17'd300;
         4'd7:    rate = 17'd600;
         4'd8:    rate = 17'd1200;
         4'd9:    rate = 17'd1800;
         4'd10:   rate = 17'd2400;
         4'd11:   rate = 17'd3600;
         4'd12:   rate = 17'd4800;
         4'd13:   rate = 17'd7200;
         4'd14:   rate = 17'd9600;
         default: rate = 17'd19200;
      endcase
      return rate;
   endfunction

endpackage

// File: sv/serial_acia_register_block_top.sv
// Serial register block in the style of a 6551 ACIA, with a receive FIFO.
// Request channel (req_*): one item per transfer, carrying a CPU read or
// write, an IRQ clear, a byte arriving from the line, a service tick or a
// master reset. Response channel (rsp_*): exactly one result per request,
// in order, with read data, the status byte, the IRQ pulse, the byte sent
// to the line and the decoded line format.
// A request transfer lands in an input register; once the result register
// is free or draining, the register logic processes it and loads the
// result register, which drives rsp_valid. One item per cycle is sustained
// while the receiver does not stall; the single processing stage that
// updates all registers and the FIFO pointers sets that rate.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; req_ready falls only when both are full.
// The receive FIFO is a memory of FIFO_DEPTH entries holding at most
// FIFO_DEPTH-2 bytes; its head is read into a register ahead of use.
// Reset is synchronous and clears both pipeline valid flags and all block
// state; FIFO contents are left as they are, the pointers mark it empty.
module serial_acia_register_block_top
   import sabr_pkg::*;
#(
   parameter int FIFO_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_reg_select,
   input  logic [7:0]  req_byte_value,
   input  logic        req_link_present,
   input  logic        req_tx_accept,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   output logic [7:0]  rsp_status_byte,
   output logic        rsp_irq_pulse,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_rx_refused,
   output logic [16:0] rsp_baud_rate,
   output logic [3:0]  rsp_word_bits,
   output logic [1:0]  rsp_stop_code,
   output logic [2:0]  rsp_parity_code,
   output logic        rsp_dtr_out,
   output logic        rsp_rts_out
);

   logic         in_valid_ff;
   req_type      in_ff;
   logic         out_valid_ff;
   rsp_type      out_ff;
   rsp_type      result;
   logic         advance;
   logic [7:0]   fifo_head;
   fifo_sts_type fifo_sts;
   fifo_ctl_type fifo_ctl;

   // Process the held item when the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.kind         <= kind_type'(req_kind);
         in_ff.reg_select   <= reg_sel_type'(req_reg_select);
         in_ff.byte_value   <= req_byte_value;
         in_ff.link_present <= req_link_present;
         in_ff.tx_accept    <= req_tx_accept;
      end
   end

   sabr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .req       (in_ff),
      .fifo_head (fifo_head),
      .fifo_sts  (fifo_sts),
      .fifo_ctl  (fifo_ctl),
      .rsp       (result)
   );

   sabr_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .wdata (in_ff.byte_value),
      .head  (fifo_head),
      .sts   (fifo_sts)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_value  = out_ff.read_value;
   assign rsp_status_byte = out_ff.status_byte;
   assign rsp_irq_pulse   = out_ff.irq_pulse;
   assign rsp_tx_valid    = out_ff.tx_valid;
   assign rsp_tx_byte     = out_ff.tx_byte;
   assign rsp_rx_refused  = out_ff.rx_refused;
   assign rsp_baud_rate   = out_ff.baud_rate;
   assign rsp_word_bits   = out_ff.word_bits;
   assign rsp_stop_code   = out_ff.stop_code;
   assign rsp_parity_code = out_ff.parity_code;
   assign rsp_dtr_out     = out_ff.dtr_out;
   assign rsp_rts_out     = out_ff.rts_out;

endmodule

// File: sv/sabr_fifo.sv
`include "serial_acia_register_block_top_defines.svh"

module sabr_fifo
   import sabr_pkg::*;
#(
   parameter int FIFO_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  fifo_ctl_type ctl,
   input  logic [7:0]   wdata,
   output logic [7:0]   head,
   output fifo_sts_type sts
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   logic [7:0]     mem [FIFO_DEPTH];
   logic [7:0]     head_ff;
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W:0]   fill;

   // Next pointers: a flush returns both to the start.
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (ctl.flush) begin
         wptr_in = '0;
         rptr_in = '0;
      end else begin
         if (ctl.push) begin
            wptr_in = (wptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (ctl.pop) begin
            rptr_in = (rptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   // Storage. The head register is read at the next read pointer so that it
   // always shows the oldest entry; a write to that same entry is forwarded.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wptr_ff] <= wdata;
      end
      if (ctl.push && (wptr_ff == rptr_in)) begin
         head_ff <= wdata;
      end else begin
         head_ff <= mem[rptr_in];
      end
   end

   // Fill level with wrap at the configured depth.
   always_comb begin
      if (wptr_ff >= rptr_ff) begin
         fill = {1'b0, wptr_ff} - {1'b0, rptr_ff};
      end else begin
         fill = {1'b0, wptr_ff} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, rptr_ff};
      end
   end

   assign head         = head_ff;
   assign sts.has_data = (wptr_ff != rptr_ff);
   assign sts.full     = (fill >= (PTR_W + 1)'(FIFO_DEPTH - 2));

   `SABR_NEVER(a_no_push_full, clock, reset, ctl.push && sts.full, "push into a full FIFO")
   `SABR_NEVER(a_no_pop_empty, clock, reset, ctl.pop && !sts.has_data, "pop from an empty FIFO")
   `SABR_ASSERT(a_flush_empties, clock, reset, ctl.flush |=> !sts.has_data, "FIFO not empty after flush")
   `SABR_NEVER(a_fill_bound, clock, reset, fill > (PTR_W + 1)'(FIFO_DEPTH - 2), "FIFO over capacity")

endmodule

// File: sv/sabr_core.sv
module sabr_core
   import sabr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_type      req,
   input  logic [7:0]   fifo_head,
   input  fifo_sts_type fifo_sts,
   output fifo_ctl_type fifo_ctl,
   output rsp_type      rsp
);

   logic [7:0]  data_ff, data_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic        ndsr_ff, ndsr_in;
   logic        ndcd_ff, ndcd_in;
   logic        ovr_ff, ovr_in;
   logic        rx_full_ff, rx_full_in;
   logic        tx_empty_ff, tx_empty_in;
   logic        irq_ff, irq_in;
   logic [7:0]  tx_hold_ff, tx_hold_in;
   logic [7:0]  retrig_ff, retrig_in;
   logic        link_ff, link_in;
   logic [4:0]  mode_ff, mode_in;
   logic [16:0] baud_ff, baud_in;
   logic [3:0]  bits_ff, bits_in;
   logic [1:0]  stop_ff, stop_in;
   logic [2:0]  parity_ff, parity_in;

   logic         do_cmd, do_ctrl, fire, tx_sent, refused;
   logic [7:0]   rd, tx_out;
   logic         dtr;
   fifo_ctl_type ctl;

   assign dtr = mode_ff[MB_DTR];

   // Next state and result for the item in the input register.
   always_comb begin
      data_in     = data_ff;
      cmd_in      = cmd_ff;
      ctrl_in     = ctrl_ff;
      ndsr_in     = ndsr_ff;
      ndcd_in     = ndcd_ff;
      ovr_in      = ovr_ff;
      rx_full_in  = rx_full_ff;
      tx_empty_in = tx_empty_ff;
      irq_in      = irq_ff;
      tx_hold_in  = tx_hold_ff;
      retrig_in   = retrig_ff;
      link_in     = link_ff;
      mode_in     = mode_ff;
      baud_in     = baud_ff;
      bits_in     = bits_ff;
      stop_in     = stop_ff;
      parity_in   = parity_ff;
      do_cmd      = 1'b0;
      do_ctrl     = 1'b0;
      fire        = 1'b0;
      tx_sent     = 1'b0;
      tx_out      = 8'h00;
      refused     = 1'b0;
      rd          = 8'h00;
      ctl         = '0;

      case (req.kind)
         KIND_READ: begin
            case (req.reg_select)
               SEL_DATA: begin
                  rd         = data_ff;
                  rx_full_in = 1'b0;
               end
               SEL_STATUS:  rd = {irq_ff, ndsr_ff, ndcd_ff, tx_empty_ff, rx_full_ff,
                                  ovr_ff, 2'b00};
               SEL_COMMAND: rd = cmd_ff;
               default:     rd = ctrl_ff;
            endcase
         end
         KIND_WRITE: begin
            case (req.reg_select)
               SEL_DATA: begin
                  tx_hold_in  = req.byte_value;
                  tx_empty_in = 1'b0;
               end
               SEL_STATUS: begin
                  // Programmed reset.
                  ovr_in  = 1'b0;
                  data_in = 8'h00;
                  cmd_in  = {cmd_ff[7:5], CMD_SOFT_LOW};
                  do_cmd  = 1'b1;
               end
               SEL_COMMAND: begin
                  cmd_in = req.byte_value;
                  do_cmd = 1'b1;
               end
               default: begin
                  ctrl_in = req.byte_value;
                  do_ctrl = 1'b1;
               end
            endcase
         end
         KIND_CLEAR_IRQ: irq_in = 1'b0;
         KIND_LINE_BYTE: begin
            if (!fifo_sts.full) begin
               ctl.push = 1'b1;
            end else begin
               refused = 1'b1;
               ovr_in  = 1'b1;
            end
         end
         KIND_TICK: begin
            if (!link_ff) begin
               // Link appears: nothing else moves on this tick.
               if (req.link_present) begin
                  link_in = 1'b1;
                  ndsr_in = 1'b0;
                  ndcd_in = 1'b0;
                  fire    = dtr;
               end
            end else if (!req.link_present) begin
               // Link lost: drop the queued bytes.
               link_in   = 1'b0;
               ctl.flush = 1'b1;
               ndsr_in   = 1'b1;
               ndcd_in   = 1'b1;
               fire      = dtr;
            end else if (dtr) begin
               // Transmit the hold byte, with optional local echo.
               if (!tx_empty_ff && req.tx_accept) begin
                  tx_sent     = 1'b1;
                  tx_out      = tx_hold_ff;
                  tx_empty_in = 1'b1;
                  if (mode_ff[MB_ECH]) begin
                     data_in    = tx_hold_ff;
                     rx_full_in = 1'b1;
                     if (mode_ff[MB_RXI]) begin
                        fire = 1'b1;
                     end
                  end else if (mode_ff[MB_TXI]) begin
                     fire = 1'b1;
                  end
               end
               // Load the next received byte, or count down to a re-interrupt.
               if (!rx_full_in) begin
                  if (fifo_sts.has_data) begin
                     data_in    = fifo_head;
                     ctl.pop    = 1'b1;
                     rx_full_in = 1'b1;
                     retrig_in  = RETRIGGER_LOAD;
                     if (mode_ff[MB_RXI]) begin
                        fire = 1'b1;
                     end
                  end
               end else begin
                  retrig_in = retrig_ff - 8'd1;
                  if ((retrig_in == 8'd0) && mode_ff[MB_RXI]) begin
                     fire = 1'b1;
                  end
               end
            end
         end
         KIND_MRESET: begin
            data_in     = 8'h00;
            cmd_in      = CMD_RESET_VALUE;
            ctrl_in     = 8'h00;
            ndsr_in     = 1'b1;
            ndcd_in     = 1'b1;
            ovr_in      = 1'b0;
            rx_full_in  = 1'b0;
            tx_empty_in = 1'b1;
            irq_in      = 1'b0;
            tx_hold_in  = 8'h00;
            retrig_in   = 8'h00;
            link_in     = 1'b0;
            mode_in     = '0;
            baud_in     = '0;
            bits_in     = '0;
            stop_in     = STOP_ONE;
            parity_in   = PARITY_NONE;
            ctl.flush   = 1'b1;
         end
         default: ;
      endcase

      // Command decode: mode bits, DCD and parity.
      if (do_cmd) begin
         mode_in = '0;
         if (cmd_in[0]) begin
            mode_in[MB_DTR] = 1'b1;
            fire            = ndcd_ff;
            ndcd_in         = 1'b0;
         end else begin
            ndcd_in = 1'b1;
         end
         mode_in[MB_RXI] = !cmd_in[1];
         mode_in[MB_RTS] = |cmd_in[3:2];
         mode_in[MB_TXI] = (cmd_in[3:2] == 2'b01);
         mode_in[MB_ECH] = cmd_in[4];
         parity_in = cmd_in[5] ? ({1'b0, cmd_in[7:6]} + 3'd1) : PARITY_NONE;
      end

      // Control decode: rate, word length and stop bits.
      if (do_ctrl) begin
         baud_in = baud_lookup(ctrl_in[3:0]);
         bits_in = 4'd8 - {2'b00, ctrl_in[6:5]};
         if (ctrl_in[7]) begin
            if ((ctrl_in[6:5] == 2'b11) && (parity_ff == PARITY_NONE)) begin
               stop_in = STOP_ONE_HALF;
            end else if ((ctrl_in[6:5] == 2'b00) && (parity_ff != PARITY_NONE)) begin
               stop_in = STOP_ONE;
            end else begin
               stop_in = STOP_TWO;
            end
         end else begin
            stop_in = STOP_ONE;
         end
      end

      if (fire) begin
         irq_in = 1'b1;
      end
   end

   // Architectural state advances once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff     <= 8'h00;
         cmd_ff      <= CMD_RESET_VALUE;
         ctrl_ff     <= 8'h00;
         ndsr_ff     <= 1'b1;
         ndcd_ff     <= 1'b1;
         ovr_ff      <= 1'b0;
         rx_full_ff  <= 1'b0;
         tx_empty_ff <= 1'b1;
         irq_ff      <= 1'b0;
         tx_hold_ff  <= 8'h00;
         retrig_ff   <= 8'h00;
         link_ff     <= 1'b0;
         mode_ff     <= '0;
         baud_ff     <= '0;
         bits_ff     <= '0;
         stop_ff     <= STOP_ONE;
         parity_ff   <= PARITY_NONE;
      end else if (step) begin
         data_ff     <= data_in;
         cmd_ff      <= cmd_in;
         ctrl_ff     <= ctrl_in;
         ndsr_ff     <= ndsr_in;
         ndcd_ff     <= ndcd_in;
         ovr_ff      <= ovr_in;
         rx_full_ff  <= rx_full_in;
         tx_empty_ff <= tx_empty_in;
         irq_ff      <= irq_in;
         tx_hold_ff  <= tx_hold_in;
         retrig_ff   <= retrig_in;
         link_ff     <= link_in;
         mode_ff     <= mode_in;
         baud_ff     <= baud_in;
         bits_ff     <= bits_in;
         stop_ff     <= stop_in;
         parity_ff   <= parity_in;
      end
   end

   // FIFO requests only count for an item actually processed.
   assign fifo_ctl = step ? ctl : '0;

   // Result of this item, taken from the updated state.
   always_comb begin
      rsp.read_value  = rd;
      rsp.status_byte = {irq_in, ndsr_in, ndcd_in, tx_empty_in, rx_full_in, ovr_in, 2'b00};
      rsp.irq_pulse   = fire;
      rsp.tx_valid    = tx_sent;
      rsp.tx_byte     = tx_out;
      rsp.rx_refused  = refused;
      rsp.baud_rate   = baud_in;
      rsp.word_bits   = bits_in;
      rsp.stop_code   = stop_in;
      rsp.parity_code = parity_in;
      rsp.dtr_out     = mode_in[MB_DTR];
      rsp.rts_out     = mode_in[MB_RTS];
   end

endmodule
